// ===== hw/rtl/slp_pkg.sv =====
// Package for the SAM alignment line parser: result record type, field
// kinds, number-parser modes and character constants. No dependencies.
package slp_pkg;

  localparam int CNT_W = 25;                     // column byte count, saturates at 2**24
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(25'h100_0000);
  localparam int OUT_DATA_W = 184;

  typedef enum logic [2:0] {
    KIND_QNAME   = 3'd0,
    KIND_RNAME   = 3'd1,
    KIND_CIGAR   = 3'd2,
    KIND_RNEXT   = 3'd3,
    KIND_BASE    = 3'd4,
    KIND_QUAL    = 3'd5,
    KIND_SUMMARY = 3'd6,
    KIND_NUMBER  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    MODE_LEAD   = 3'd0,
    MODE_SIGNED = 3'd1,
    MODE_ZERO   = 3'd2,
    MODE_HEXPFX = 3'd3,
    MODE_DEC    = 3'd4,
    MODE_OCT    = 3'd5,
    MODE_HEX    = 3'd6
  } num_mode_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD_QUAL = 4'd11;
  localparam logic [3:0] ST_MISMATCH = 4'd12;
  localparam logic [3:0] ST_BAD_SEQ  = 4'd10;

  localparam logic [3:0] COL_QNAME = 4'd0;
  localparam logic [3:0] COL_FLAG  = 4'd1;
  localparam logic [3:0] COL_POS   = 4'd3;
  localparam logic [3:0] COL_MAPQ  = 4'd4;
  localparam logic [3:0] COL_PNEXT = 4'd7;
  localparam logic [3:0] COL_TLEN  = 4'd8;
  localparam logic [3:0] COL_SEQ   = 4'd9;
  localparam logic [3:0] COL_QUAL  = 4'd10;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_EOF = 8'h1A;
  localparam logic [7:0] QUAL_OFFSET_RESET = 8'd33;

  typedef struct packed {
    logic [2:0]         item_kind;
    logic [7:0]         data_byte;
    logic [15:0]        byte_index;
    logic [31:0]        flag_word;
    logic signed [32:0] zero_based_pos;
    logic [7:0]         mapping_quality;
    logic [31:0]        mate_pos;
    logic signed [31:0] template_length;
    logic [15:0]        sequence_length;
    logic [3:0]         status;
  } result_t;

  function automatic kind_t col_kind(input logic [3:0] f);
    kind_t k;
    unique case (f)
      4'd0:    k = KIND_QNAME;
      4'd2:    k = KIND_RNAME;
      4'd5:    k = KIND_CIGAR;
      4'd6:    k = KIND_RNEXT;
      4'd9:    k = KIND_BASE;
      4'd10:   k = KIND_QUAL;
      default: k = KIND_NUMBER;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/slp_front.sv =====
// Front end of the SAM line parser: takes one text byte per transaction,
// tracks columns, parses numeric columns and builds result records. Uses slp_pkg.
module slp_front #(
  parameter int MAX_SEQ_LEN = 65535
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  input  logic                 room,
  input  logic [7:0]           qoff,
  output logic                 res_valid,
  output slp_pkg::result_t     res
);
  import slp_pkg::*;

  logic [3:0]       field_r, field_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [31:0]      acc_r, acc_nxt;
  num_mode_t        mode_r, mode_nxt;
  logic             neg_r, neg_nxt, seen_r, seen_nxt, skip_r, skip_nxt;
  logic [31:0]      hflag_r, hflag_nxt, hmate_r, hmate_nxt, htlen_r, htlen_nxt;
  logic [32:0]      hpos_r, hpos_nxt;
  logic [7:0]       hmapq_r, hmapq_nxt;
  logic [CNT_W-1:0] hseq_r, hseq_nxt;

  logic        fire, le, blank, dig09, num_ok, cl_ok;
  logic [4:0]  d;
  logic [36:0] a10, a8, a16;
  logic [31:0] val;
  logic [3:0]  fin_st;
  kind_t       kind;
  num_mode_t   nm;
  logic [31:0] na;
  logic        nn, ns;

  function automatic result_t mk_sum(input logic [3:0] st, input logic [31:0] fl,
                                     input logic [32:0] ps, input logic [7:0] mq,
                                     input logic [31:0] mt, input logic [31:0] tl,
                                     input logic [15:0] sl);
    result_t r;
    r = '0;
    r.item_kind = KIND_SUMMARY;
    r.status = st;
    if (st == ST_OK) begin
      r.flag_word = fl;
      r.zero_based_pos = ps;
      r.mapping_quality = mq;
      r.mate_pos = mt;
      r.template_length = tl;
      r.sequence_length = sl;
    end
    return r;
  endfunction

  assign fire = byte_valid && room;
  assign le = (byte_data == CH_NUL) || (byte_data == CH_LF) || (byte_data == CH_CR) ||
              (byte_data == CH_EOF);
  assign blank = (byte_data == 8'h20) || (byte_data == 8'h0B) || (byte_data == 8'h0C);
  assign dig09 = (byte_data >= 8'h30) && (byte_data <= 8'h39);
  assign kind = col_kind(field_r);
  assign cnt_inc = (cnt_r < CNT_CAP) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    if (dig09) d = 5'(byte_data - 8'h30);
    else if (byte_data >= 8'h61 && byte_data <= 8'h66) d = 5'(byte_data - 8'h57);
    else if (byte_data >= 8'h41 && byte_data <= 8'h46) d = 5'(byte_data - 8'h37);
    else d = 5'd16;
  end

  assign a10 = {2'b0, acc_r, 3'b0} + {4'b0, acc_r, 1'b0} + {33'b0, d[3:0]};
  assign a8  = {2'b0, acc_r, 3'b0} + {33'b0, d[3:0]};
  assign a16 = {1'b0, acc_r, 4'b0} + {33'b0, d[3:0]};

  // One character of a numeric column.
  always_comb begin
    nm = mode_r; na = acc_r; nn = neg_r; ns = seen_r; num_ok = 1'b0;
    unique case (mode_r)
      MODE_LEAD, MODE_SIGNED: begin
        if (mode_r == MODE_LEAD && blank) begin
          num_ok = 1'b1;
        end else if (mode_r == MODE_LEAD && byte_data == 8'h2B) begin
          nm = MODE_SIGNED; num_ok = 1'b1;
        end else if (mode_r == MODE_LEAD && byte_data == 8'h2D) begin
          nn = 1'b1; nm = MODE_SIGNED; num_ok = 1'b1;
        end else if (byte_data == 8'h30) begin
          nm = MODE_ZERO; ns = 1'b1; num_ok = 1'b1;
        end else if (dig09) begin
          nm = MODE_DEC; ns = 1'b1; na = a10[31:0]; num_ok = (a10[36:32] == '0);
        end
      end
      MODE_ZERO: begin
        if (byte_data == 8'h78 || byte_data == 8'h58) begin
          nm = MODE_HEXPFX; num_ok = 1'b1;
        end else begin
          nm = MODE_OCT; ns = 1'b1; na = a8[31:0];
          num_ok = dig09 && (d < 5'd8) && (a8[36:32] == '0);
        end
      end
      MODE_HEXPFX, MODE_HEX: begin
        nm = MODE_HEX; ns = 1'b1; na = a16[31:0];
        num_ok = (d < 5'd16) && (a16[36:32] == '0);
      end
      MODE_DEC: begin
        ns = 1'b1; na = a10[31:0]; num_ok = dig09 && (a10[36:32] == '0);
      end
      MODE_OCT: begin
        ns = 1'b1; na = a8[31:0]; num_ok = dig09 && (d < 5'd8) && (a8[36:32] == '0);
      end
      default: num_ok = 1'b0;
    endcase
  end

  assign cl_ok = seen_r && (mode_r != MODE_HEXPFX) &&
                 !((field_r == COL_TLEN) && (acc_r > (neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF)));
  assign val = neg_r ? (32'd0 - acc_r) : acc_r;
  assign fin_st = (cnt_r == '0) ? ST_BAD_QUAL : ((cnt_r != hseq_r) ? ST_MISMATCH : ST_OK);

  always_comb begin
    field_nxt = field_r; cnt_nxt = cnt_r; acc_nxt = acc_r; mode_nxt = mode_r;
    neg_nxt = neg_r; seen_nxt = seen_r; skip_nxt = skip_r;
    hflag_nxt = hflag_r; hpos_nxt = hpos_r; hmapq_nxt = hmapq_r;
    hmate_nxt = hmate_r; htlen_nxt = htlen_r; hseq_nxt = hseq_r;
    res_valid = 1'b0;
    res = '0;
    if (fire) begin
      priority if (skip_r || le) begin
        if (le) begin
          if (!skip_r && !(field_r == COL_QNAME && cnt_r == '0)) begin
            res_valid = 1'b1;
            res = mk_sum((field_r == COL_QUAL) ? fin_st : field_r + 4'd1, hflag_r, hpos_r,
                         hmapq_r, hmate_r, htlen_r, hseq_r[15:0]);
          end
          field_nxt = COL_QNAME; skip_nxt = 1'b0; cnt_nxt = '0; acc_nxt = '0;
          mode_nxt = MODE_LEAD; neg_nxt = 1'b0; seen_nxt = 1'b0;
        end
      end else if (byte_data == CH_TAB) begin
        if (field_r == COL_QUAL) begin
          res_valid = 1'b1; skip_nxt = 1'b1;
          res = mk_sum(fin_st, hflag_r, hpos_r, hmapq_r, hmate_r, htlen_r, hseq_r[15:0]);
        end else if (cnt_r == '0 || (kind == KIND_NUMBER && !cl_ok)) begin
          res_valid = 1'b1; skip_nxt = 1'b1;
          res = mk_sum(field_r + 4'd1, hflag_r, hpos_r, hmapq_r, hmate_r, htlen_r,
                       hseq_r[15:0]);
        end else begin
          if (kind == KIND_NUMBER) begin
            unique case (field_r)
              COL_FLAG:  hflag_nxt = val;
              COL_POS:   hpos_nxt = {1'b0, val} - 33'd1;
              COL_MAPQ:  hmapq_nxt = val[7:0];
              COL_PNEXT: hmate_nxt = val;
              default:   htlen_nxt = val;
            endcase
          end
          if (field_r == COL_SEQ) hseq_nxt = cnt_r;
          field_nxt = field_r + 4'd1; cnt_nxt = '0; acc_nxt = '0;
          mode_nxt = MODE_LEAD; neg_nxt = 1'b0; seen_nxt = 1'b0;
        end
      end else if (kind == KIND_NUMBER) begin
        cnt_nxt = cnt_inc; acc_nxt = na; mode_nxt = nm; neg_nxt = nn; seen_nxt = ns;
        if (!num_ok) begin
          res_valid = 1'b1; skip_nxt = 1'b1;
          res = mk_sum(field_r + 4'd1, hflag_r, hpos_r, hmapq_r, hmate_r, htlen_r,
                       hseq_r[15:0]);
        end
      end else if (field_r == COL_SEQ && cnt_r >= CNT_W'(MAX_SEQ_LEN)) begin
        res_valid = 1'b1; skip_nxt = 1'b1;
        res = mk_sum(ST_BAD_SEQ, hflag_r, hpos_r, hmapq_r, hmate_r, htlen_r, hseq_r[15:0]);
      end else begin
        res_valid = 1'b1;
        res.item_kind = kind;
        res.data_byte = (field_r == COL_QUAL) ? byte_data - qoff : byte_data;
        res.byte_index = cnt_r[15:0];
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= COL_QNAME; cnt_r <= '0; acc_r <= '0; mode_r <= MODE_LEAD;
      neg_r <= 1'b0; seen_r <= 1'b0; skip_r <= 1'b0;
      hflag_r <= '0; hpos_r <= '0; hmapq_r <= '0; hmate_r <= '0; htlen_r <= '0;
      hseq_r <= '0;
    end else begin
      field_r <= field_nxt; cnt_r <= cnt_nxt; acc_r <= acc_nxt; mode_r <= mode_nxt;
      neg_r <= neg_nxt; seen_r <= seen_nxt; skip_r <= skip_nxt;
      hflag_r <= hflag_nxt; hpos_r <= hpos_nxt; hmapq_r <= hmapq_nxt;
      hmate_r <= hmate_nxt; htlen_r <= htlen_nxt; hseq_r <= hseq_nxt;
    end
  end

endmodule

// ===== hw/rtl/slp_queue.sv =====
// Back end of the SAM line parser: a two-entry result queue whose head
// drives the output stream directly from registers. Uses slp_pkg.
module slp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  slp_pkg::result_t  push_data,
  output logic              room,
  output logic              head_valid,
  output slp_pkg::result_t  head_data,
  input  logic              pop_ready
);
  import slp_pkg::*;

  result_t    mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data = mem_r[rp_r];
  assign pop = head_valid && pop_ready;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/sam_alignment_line_parser_core.sv =====
// Results: the result of a text byte is pushed into the queue at the same edge that
// accepts the byte, and out_* shows it once it reaches the queue head.
// Throughput: one byte per cycle; the front parser takes a byte whenever the
// two-entry result queue has room, so output stalls only back up after two results.
// Reset: synchronous, active low; clears column state, held values and the queue,
// and sets the quality offset to 33.
module sam_alignment_line_parser_core #(
  parameter int MAX_SEQ_LEN = 65535
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] text_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [slp_pkg::OUT_DATA_W-1:0] out_tdata,
    // [7:0] data_byte, [23:8] byte_index, [55:24] flag_word, [88:56] zero_based_pos,
    // [96:89] mapping_quality, [128:97] mate_pos, [160:129] template_length,
    // [176:161] sequence_length, [180:177] status, [183:181] zero
  output logic [2:0]   out_tuser,  // [2:0] item_kind
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data    // quality_offset
);
  import slp_pkg::*;

  // Quality offset register: always writable; users must change it only while idle.
  logic [7:0] qoff_r;
  logic       room, res_valid;
  result_t    res, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) qoff_r <= QUAL_OFFSET_RESET;
    else if (cfg_valid) qoff_r <= cfg_data;
  end

  // The front end accepts a byte whenever the queue has space for one result.
  assign in_tready = room;

  slp_front #(.MAX_SEQ_LEN(MAX_SEQ_LEN)) u_front (
    .clk(clk), .rst_n(rst_n), .byte_valid(in_tvalid), .byte_data(in_tdata),
    .room(room), .qoff(qoff_r), .res_valid(res_valid), .res(res)
  );

  slp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res), .room(room),
    .head_valid(out_tvalid), .head_data(head), .pop_ready(out_tready)
  );

  assign out_tuser = head.item_kind;
  assign out_tdata = {3'b0, head.status, head.sequence_length, head.template_length,
                      head.mate_pos, head.mapping_quality, head.zero_based_pos,
                      head.flag_word, head.byte_index, head.data_byte};

endmodule

// ===== hw/rtl/slp_checker.sv =====
// Port-level checks for sam_alignment_line_parser_core, attached by bind.
// Depends on the top level's port list and slp_pkg.
module slp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [slp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]                     out_tuser
);
  import slp_pkg::*;

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= 3'(KIND_SUMMARY))) else $error("item kind out of range");

  a_byte_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != 3'(KIND_SUMMARY)) |-> (out_tdata[183:24] == '0))
    else $error("byte item carries summary fields");

  a_error_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == 3'(KIND_SUMMARY) && out_tdata[180:177] != ST_OK) |->
      (out_tdata[176:0] == '0)) else $error("error summary carries values");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind sam_alignment_line_parser_core slp_checker u_slp_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

// ===== tb/sv/tb_sam_alignment_line_parser_core.sv =====
// Self-checking testbench for the SAM alignment line parser core.
// Drives SAM text over the input stream, predicts every result transaction in a
// scoreboard class and compares it field by field. Depends on slp_pkg and the core.
`timescale 1ns / 1ps

module tb_sam_alignment_line_parser_core;
  import slp_pkg::*;

  // Predicted result transaction in the block's own field widths.
  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [31:0] flag;
    logic [32:0] pos;
    logic [7:0]  mapq;
    logic [31:0] pnext;
    logic [31:0] tlen;
    logic [15:0] seqlen;
    logic [3:0]  status;
  } sam_result_t;

  // The scoreboard keeps its own copy of the parser state and the queue of
  // results that it still expects to see on the output stream.
  class sam_scoreboard;
    sam_result_t pending[$];
    int          errors;
    logic [7:0]  qual_offset;
    int unsigned col;
    int unsigned count;
    logic [63:0] acc;
    num_mode_t   mode;
    bit          neg;
    bit          seen;
    bit          skipping;
    logic [31:0] h_flag;
    logic [32:0] h_pos;
    logic [7:0]  h_mapq;
    logic [31:0] h_pnext;
    logic [31:0] h_tlen;
    logic [15:0] h_seqlen;

    function void reset_state();
      qual_offset = QUAL_OFFSET_RESET;
      h_flag = 0; h_pos = 0; h_mapq = 0; h_pnext = 0; h_tlen = 0; h_seqlen = 0;
      errors = 0;
      new_line();
    endfunction

    function void clear_col();
      count = 0; acc = 0; mode = MODE_LEAD; neg = 0; seen = 0;
    endfunction

    function void new_line();
      col = 0; skipping = 0;
      clear_col();
    endfunction

    function void push_byte(logic [2:0] k, logic [7:0] d, int unsigned i);
      sam_result_t r;
      r = '{default: '0};
      r.kind = k; r.data = d; r.idx = i[15:0];
      pending.push_back(r);
    endfunction

    function void push_summary(logic [3:0] st);
      sam_result_t r;
      r = '{default: '0};
      r.kind = KIND_SUMMARY;
      r.status = st;
      if (st == ST_OK) begin
        r.flag = h_flag; r.pos = h_pos; r.mapq = h_mapq;
        r.pnext = h_pnext; r.tlen = h_tlen; r.seqlen = h_seqlen;
      end
      pending.push_back(r);
    endfunction

    function bit add_digit(int unsigned radix, int d);
      if (d < 0 || d >= radix) return 0;
      acc = acc * radix + d;
      seen = 1;
      return acc <= 64'hFFFF_FFFF;
    endfunction

    // One character of a numeric column; returns 0 on a syntax error or overflow.
    function bit number_char(logic [7:0] c);
      int d;
      bit dec;
      dec = (c >= "0" && c <= "9");
      if (dec) d = c - "0";
      else if (c >= "a" && c <= "f") d = c - "a" + 10;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      else d = 99;
      if (mode == MODE_LEAD) begin
        if (c == " " || c == 8'd11 || c == 8'd12) return 1;
        if (c == "+") begin mode = MODE_SIGNED; return 1; end
        if (c == "-") begin neg = 1; mode = MODE_SIGNED; return 1; end
      end
      case (mode)
        MODE_LEAD, MODE_SIGNED: begin
          if (c == "0") begin mode = MODE_ZERO; seen = 1; return 1; end
          if (c < "1" || c > "9") return 0;
          mode = MODE_DEC;
          return add_digit(10, d);
        end
        MODE_ZERO: begin
          if (c == "x" || c == "X") begin mode = MODE_HEXPFX; return 1; end
          mode = MODE_OCT;
          return dec && add_digit(8, d);
        end
        MODE_HEXPFX, MODE_HEX: begin
          mode = MODE_HEX;
          return add_digit(16, d);
        end
        MODE_DEC: return dec && add_digit(10, d);
        MODE_OCT: return dec && add_digit(8, d);
        default:  return 0;
      endcase
    endfunction

    function bit close_number(int unsigned f);
      logic [31:0] v;
      if (!seen || mode == MODE_HEXPFX) return 0;
      if (f == COL_TLEN && acc > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) return 0;
      v = neg ? (32'd0 - acc[31:0]) : acc[31:0];
      case (f)
        COL_FLAG:  h_flag = v;
        COL_POS:   h_pos = {1'b0, v} + 33'h1_FFFF_FFFF;
        COL_MAPQ:  h_mapq = v[7:0];
        COL_PNEXT: h_pnext = v;
        default:   h_tlen = v;
      endcase
      return 1;
    endfunction

    function logic [3:0] record_status();
      if (count == 0) return ST_BAD_QUAL;
      if (count != h_seqlen) return ST_MISMATCH;
      return ST_OK;
    endfunction

    // Note an accepted text byte and queue the results it causes.
    function void note_byte(logic [7:0] c);
      bit eol;
      int unsigned f;
      kind_t k;
      eol = (c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_EOF);
      f = (col > COL_QUAL) ? COL_QUAL : col;
      k = col_kind(f[3:0]);
      if (skipping) begin
        if (eol) new_line();
        return;
      end
      if (eol) begin
        if (f == COL_QNAME && count == 0) begin new_line(); return; end
        if (f == COL_QUAL) push_summary(record_status());
        else push_summary(4'(f + 1));
        new_line();
        return;
      end
      if (c == CH_TAB) begin
        if (f == COL_QUAL) begin
          push_summary(record_status());
          skipping = 1;
          return;
        end
        if (count == 0 || (k == KIND_NUMBER && !close_number(f))) begin
          skipping = 1;
          push_summary(4'(f + 1));
          return;
        end
        if (f == COL_SEQ) h_seqlen = count[15:0];
        col = f + 1;
        clear_col();
        return;
      end
      if (k == KIND_NUMBER) begin
        if (count < CNT_CAP) count++;
        if (!number_char(c)) begin
          skipping = 1;
          push_summary(4'(f + 1));
        end
        return;
      end
      if (f == COL_SEQ && count >= 65535) begin
        skipping = 1;
        push_summary(ST_BAD_SEQ);
        return;
      end
      push_byte(k, (f == COL_QUAL) ? c - qual_offset : c, count);
      if (count < CNT_CAP) count++;
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Check one accepted result transaction against the oldest expectation.
    function void check_result(logic [2:0] kind, logic [OUT_DATA_W-1:0] d);
      sam_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: kind %0d", kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      compare("item_kind", e.kind, kind);
      compare("data_byte", e.data, d[7:0]);
      compare("byte_index", e.idx, d[23:8]);
      compare("flag_word", e.flag, d[55:24]);
      compare("zero_based_pos", e.pos, d[88:56]);
      compare("mapping_quality", e.mapq, d[96:89]);
      compare("mate_pos", e.pnext, d[128:97]);
      compare("template_length", e.tlen, d[160:129]);
      compare("sequence_length", e.seqlen, d[176:161]);
      compare("status", e.status, d[180:177]);
      compare("pad", 0, d[183:181]);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_data = 0;

  sam_scoreboard sb;
  byte unsigned text_q[$];     // bytes of the current phase, sent in order
  int          sent_bytes;
  int          idle_cycles;
  bit          rx_enable;

  always #5 clk = ~clk;

  sam_alignment_line_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Sample every handshake at the rising edge; the predictor sees input
  // transactions in acceptance order, so results are always queued in time.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (cfg_valid && cfg_ready) sb.qual_offset = cfg_data;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // The receiver draws a random wait for every result transaction while rx_enable is set;
  // in the directed phases it keeps tready high throughout.
  initial begin
    int w;
    wait (rst_n);
    forever begin
      w = rx_enable ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 2) != 0) w = 0;
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Send the queued text; the sender gap is drawn per byte, except in calm stretches.
  task automatic send_text(input bit calm);
    int w;
    byte unsigned b;
    while (text_q.size() > 0) begin
      b = text_q.pop_front();
      w = calm ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 2) != 0) w = 0;
      if (w > 0) begin
        in_tvalid <= 0;
        repeat (w) @(negedge clk);
      end
      in_tvalid <= 1;
      in_tdata  <= b;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sent_bytes++;
      @(negedge clk);
    end
    in_tvalid <= 0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_offset(input logic [7:0] v);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // A random number in one of the strtol forms, sometimes with a leading blank or a sign.
  function automatic string rand_number(input bit wide);
    string s;
    int unsigned v;
    s = "";
    v = wide ? $urandom() : $urandom_range(0, 300);
    if ($urandom_range(0, 5) == 0) s = " ";
    case ($urandom_range(0, 5))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: s = {s, $sformatf("0x%0h", v)};
      1: s = {s, $sformatf("0%0o", v)};
      default: s = {s, $sformatf("%0d", v)};
    endcase
    return s;
  endfunction

  function automatic string rand_text(input int n, input byte unsigned lo,
                                      input byte unsigned hi);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(lo, hi)))};
    return s;
  endfunction

  // A well-formed record with random content, occasionally with a quality
  // length mismatch or a broken column.
  task automatic add_record();
    int n, q;
    string tl;
    n = $urandom_range(1, 6);
    q = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : n;
    tl = ($urandom_range(0, 1) == 0) ? rand_number(0) :
         $sformatf("%0d", $signed($urandom()));
    add_str({rand_text($urandom_range(1, 4), 8'h21, 8'h7e), "\t", rand_number(1), "\t",
             rand_text($urandom_range(1, 3), 8'h21, 8'h7e), "\t", rand_number(1), "\t",
             rand_number(1), "\t", rand_text($urandom_range(1, 3), 8'h21, 8'h7e), "\t",
             rand_text(1, 8'h21, 8'h7e), "\t", rand_number(1), "\t", tl, "\t",
             rand_text(n, 8'h41, 8'h5a), "\t", rand_text(q, 8'h00, 8'hff)});
  endtask

  initial begin
    int cut, sel, sp;
    sb = new();
    sb.reset_state();
    sent_bytes = 0;
    idle_cycles = 0;
    rx_enable = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: default offset, extremes of the numbers, hex, octal, blanks,
    // negative unsigned values, TLEN limits, empty line and the error cases.
    add_str("r1\t4294967295\tchr\t0\t65535\t4M\t=\t0x0\t-2147483648\tACGT\t!!~~\tNM:i:0\n");
    add_str("\n");
    add_str("r\t -0x1F\tc\t+017\t0\t*\t*\t0\t2147483647\tA\tI\r");
    add_str("\t1\n");                     // empty QNAME
    add_str("r\t0x\tc\n");                // hex prefix with no digits
    add_str("r\t1 2\tc\n");               // blank after a digit
    add_str("r\t4294967296\t\n");         // overflow
    add_str("r\t0\tc\t1\t1\tM\t=\t1\t2147483648\tA\tI\n");  // TLEN out of range
    add_str("r\t0\tc\t1\t1\tM\t=\t1\t1\tAC\tI\n");          // length mismatch
    add_str("r\t0\tc\t1\t1\tM\t=\t1\t1\tA\t\n");            // empty QUAL
    add_str("r\t0\tc\t1\032");            // line end before QUAL
    add_str("r\t08\t");                   // bad octal digit
    text_q.push_back(8'h00);
    send_text(1);
    wait_drained();

    // Extreme offsets: the maximum, with quality bytes 0x01, 0x80, 0xFF, 0x7F, then zero.
    write_offset(8'hFF);
    add_str("q\t0\tc\t1\t1\tM\t=\t1\t1\tAAAA\t");
    text_q.push_back(8'h00 + 8'h01); text_q.push_back(8'h80);
    text_q.push_back(8'hFF); text_q.push_back(8'h7F);
    add_str("\n");
    send_text(1);
    wait_drained();
    write_offset(8'h00);

    // Random phases; each phase ends idle so the offset can change.
    rx_enable = 1;
    while (sent_bytes < 1000) begin
      for (int r = 0; r < 12 && sent_bytes + text_q.size() < 1050; r++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          add_record();
          add_str(($urandom_range(0, 1) == 0) ? "\n" : "\tXX:Z:t\r");
        end else if (sel == 7) begin
          add_record();
          cut = $urandom_range(1, text_q.size());
          while (text_q.size() > cut) void'(text_q.pop_back());
          add_str("\n");
        end else begin
          // Noise: any byte value, ended by a line end so the next record starts clean.
          add_str(rand_text($urandom_range(1, 20), 8'h00, 8'hff));
          add_str("\n");
        end
      end
      send_text($urandom_range(0, 3) == 0);
      wait_drained();
      write_offset(8'($urandom()));
    end
    write_offset(QUAL_OFFSET_RESET);
    repeat (20) @(negedge clk);

    $display("Covered %0d text bytes: records, noise, truncated lines, malformed and",
             sent_bytes);
    $display("overflowing numbers, length mismatches and quality offsets from 0 to 255.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/slp_pkg.sv
hw/rtl/slp_front.sv
hw/rtl/slp_queue.sv
hw/rtl/sam_alignment_line_parser_core.sv
hw/rtl/slp_checker.sv
tb/sv/tb_sam_alignment_line_parser_core.sv
